/* rtl/attenuating_particle_step_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the particle stepper
// Shorthand for clocked assertions on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ATTENUATING_PARTICLE_STEP_TOP_ASSERT_SVH
`define ATTENUATING_PARTICLE_STEP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aps_pkg.sv */
// ----------------------------------------------------------------------------
// aps_pkg
// Types, codes and constants of the particle stepper.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int unsigned PATH_SCALE_DEF = 50;
  localparam int unsigned SCALE_W        = 16;
  localparam int unsigned APB_AW         = 5;

  localparam logic [23:0] SPEED_RST  = 24'd256;
  localparam logic [23:0] BASE_RST   = 24'd2560000;
  localparam logic [23:0] DEATH_RST  = 24'd26;
  localparam logic [15:0] ATTEN_RST  = 16'd256;
  localparam logic [15:0] ENERGY_RST = 16'd16384;

  localparam logic [30:0] EXP_M1_Q32   = 31'd1580030169;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
  localparam logic [3:0]  SERIES_TERMS = 4'd12;

  // shared multiplier and divider geometry
  localparam int unsigned MUL_W   = 34;
  localparam int unsigned ACC_W   = 72;
  localparam int unsigned DIV_W   = 48;
  localparam int unsigned DIV_R   = 4;
  localparam logic [3:0]  DIV_CYC = 4'(DIV_W / DIV_R);

  typedef enum logic {
    REQ_LAUNCH = 1'b0,
    REQ_TICK   = 1'b1
  } aps_req_e;

  typedef enum logic [2:0] {
    REG_SPEED  = 3'd0,
    REG_BASE   = 3'd1,
    REG_DEATH  = 3'd2,
    REG_ATTEN  = 3'd3,
    REG_ENERGY = 3'd4
  } aps_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SD, ST_DXLO, ST_DXHI, ST_DYLO, ST_DYHI,
    ST_SQX, ST_SQY, ST_SQLD, ST_SQRT, ST_PATH, ST_ATT,
    ST_DIVLD, ST_DIVP, ST_XSET, ST_TMUL, ST_TDLD, ST_TDIV,
    ST_TACC, ST_EMUL, ST_EWB, ST_AMP1, ST_AMP2, ST_AMP3,
    ST_AMP4, ST_FINISH
  } aps_state_e;

endpackage

/* rtl/aps_if.sv */
// ----------------------------------------------------------------------------
// aps_in_if / aps_out_if
// Valid/ready channels carrying requests and particle results.
// ----------------------------------------------------------------------------
interface aps_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic        [15:0] dt;

  modport source (output valid, req_type, start_x, start_y, dir_x, dir_y, dt,
                  input ready);
  modport sink   (input valid, req_type, start_x, start_y, dir_x, dir_y, dt,
                  output ready);
endinterface

interface aps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic        [23:0] amplitude;
  logic        [31:0] travelled;
  logic        [31:0] age;
  logic               is_dead;

  modport source (output valid, cur_x, cur_y, prev_x, prev_y, amplitude, travelled,
                  age, is_dead, input ready);
  modport sink   (input valid, cur_x, cur_y, prev_x, prev_y, amplitude, travelled,
                  age, is_dead, output ready);
endinterface

/* rtl/attenuating_particle_step_top.sv */
// ----------------------------------------------------------------------------
// attenuating_particle_step_top
// Moves one acoustic particle per tick and attenuates its amplitude with path.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           contents
//  in_i      in   valid/ready         launch or tick request transaction
//  out_o     out  valid/ready         particle state after the request
//  apb       in   psel/penable/pready register writes and reads
//
//  A launch goes from idle to the finish state. A tick runs the twelve
//  series terms, each a multiply plus a division on the shared radix-16
//  divider, unless its decay underflows; the 32 step square root and up
//  to 31 rounding multiplies by 1/e make up most of the rest. Shortest is
//  a tick whose squared length overflows and whose decay underflows.
//  The input is ready only while the sequencer idles; a finished result
//  waits in the output register and holds the sequencer until taken.
//  Reset is asynchronous, active low, and clears control and particle state.
// ----------------------------------------------------------------------------
module attenuating_particle_step_top #(
  parameter int unsigned PATH_SCALE = aps_pkg::PATH_SCALE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  aps_in_if.sink                     in_i,
  aps_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aps_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned MW = aps_pkg::MUL_W;
  localparam int unsigned AW = aps_pkg::ACC_W;
  localparam int unsigned DW = aps_pkg::DIV_W;
  localparam logic [aps_pkg::SCALE_W-1:0] SCALE = aps_pkg::SCALE_W'(PATH_SCALE);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] speed_q, base_q, death_q;
  logic [15:0] atten_q, energy_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= aps_pkg::SPEED_RST;
      base_q   <= aps_pkg::BASE_RST;
      death_q  <= aps_pkg::DEATH_RST;
      atten_q  <= aps_pkg::ATTEN_RST;
      energy_q <= aps_pkg::ENERGY_RST;
    end else if (cfg_wr) begin
      unique case (aps_pkg::aps_reg_e'(paddr[4:2]))
        aps_pkg::REG_SPEED:  speed_q  <= pwdata[23:0];
        aps_pkg::REG_BASE:   base_q   <= pwdata[23:0];
        aps_pkg::REG_DEATH:  death_q  <= pwdata[23:0];
        aps_pkg::REG_ATTEN:  atten_q  <= pwdata[15:0];
        aps_pkg::REG_ENERGY: energy_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (aps_pkg::aps_reg_e'(paddr[4:2]))
      aps_pkg::REG_SPEED:  prdata = {8'd0, speed_q};
      aps_pkg::REG_BASE:   prdata = {8'd0, base_q};
      aps_pkg::REG_DEATH:  prdata = {8'd0, death_q};
      aps_pkg::REG_ATTEN:  prdata = {16'd0, atten_q};
      aps_pkg::REG_ENERGY: prdata = {16'd0, energy_q};
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Particle state and working registers
  // --------------------------------------------------------------------------
  aps_pkg::aps_state_e state_q, state_d;

  logic signed [31:0] cur_x_q, cur_y_q, prv_x_q, prv_y_q;
  logic signed [15:0] head_x_q, head_y_q;
  logic        [31:0] age_q, path_q;
  logic        [23:0] amp_q;
  logic               dead_q;

  logic [15:0]   dt_q;
  logic [39:0]   sd_q;
  logic [AW-1:0] prod_q;
  logic [33:0]   dmx_q, dmy_q;
  logic [63:0]   sqx_q, sq_v_q, sq_r_q, sq_bit_q;
  logic          sq_ovf_q;
  logic [15:0]   div_rem_q;
  logic [DW-1:0] div_quo_q;
  logic [3:0]    div_cnt_q;
  logic [23:0]   xf_q;
  logic [4:0]    n_q;
  logic [32:0]   term_q, sum_q;
  logic [3:0]    k_q;
  logic [40:0]   t_q;

  logic          out_valid_q;
  logic          in_fire, out_free;

  assign in_i.ready = (state_q == aps_pkg::ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Magnitudes of the heading components (up to 2^15)
  logic [15:0] magx, magy;
  assign magx = head_x_q[15] ? (~head_x_q + 16'd1) : head_x_q;
  assign magy = head_y_q[15] ? (~head_y_q + 16'd1) : head_y_q;

  logic [31:0] ax, ay;
  assign ax = (dmx_q[33:32] != 2'd0) ? 32'hFFFF_FFFF : dmx_q[31:0];
  assign ay = (dmy_q[33:32] != 2'd0) ? 32'hFFFF_FFFF : dmy_q[31:0];

  // --------------------------------------------------------------------------
  // Shared multiplier: product loads or accumulates, optionally shifted up by MW bits
  // --------------------------------------------------------------------------
  logic          mul_en, mul_acc, mul_hi;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] mul_p;
  logic [AW-1:0] mul_term;

  assign mul_p    = mul_a * mul_b;
  assign mul_term = mul_hi ? AW'({mul_p, {MW{1'b0}}}) : AW'(mul_p);

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= (mul_acc ? prod_q : '0) + mul_term;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider: restoring, DIV_R quotient bits per cycle
  // --------------------------------------------------------------------------
  logic [15:0]   div_den;
  logic [15:0]   div_rem_n;
  logic [DW-1:0] div_quo_n;

  assign div_den = (state_q == aps_pkg::ST_DIVP) ? SCALE : {12'd0, k_q};

  always_comb begin
    logic [16:0] sh;
    div_rem_n = div_rem_q;
    div_quo_n = div_quo_q;
    for (int i = 0; i < int'(aps_pkg::DIV_R); i++) begin
      sh        = {div_rem_n, div_quo_n[DW-1]};
      div_quo_n = {div_quo_n[DW-2:0], 1'b0};
      if (sh >= {1'b0, div_den}) begin
        div_rem_n    = 16'(sh - {1'b0, div_den});
        div_quo_n[0] = 1'b1;
      end else begin
        div_rem_n = sh[15:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root step (digit by digit)
  // --------------------------------------------------------------------------
  logic [63:0] sq_rb;
  logic        sq_ge;
  assign sq_rb = sq_r_q + sq_bit_q;
  assign sq_ge = (sq_v_q >= sq_rb);

  // --------------------------------------------------------------------------
  // Combinational values used when a tick closes
  // --------------------------------------------------------------------------
  logic [64:0] sq_sum;
  logic [31:0] len;
  logic [32:0] path_sum, age_sum;
  logic [41:0] amp_raw;
  logic [23:0] amp_new;
  logic signed [35:0] nx, ny;
  logic signed [31:0] nx_sat, ny_sat;
  logic [65:0] e_round;

  assign sq_sum   = {1'b0, sqx_q} + {1'b0, prod_q[63:0]};
  assign len      = sq_ovf_q ? 32'hFFFF_FFFF : sq_r_q[31:0];
  assign path_sum = {1'b0, path_q} + {1'b0, len};
  assign age_sum  = {1'b0, age_q} + {17'd0, dt_q};
  assign amp_raw  = prod_q[71:30];
  assign amp_new  = (amp_raw > {18'd0, base_q}) ? base_q : amp_raw[23:0];
  assign e_round  = prod_q[65:0] + 66'h8000_0000;

  assign nx = head_x_q[15] ? (36'(cur_x_q) - $signed({2'b00, dmx_q}))
                           : (36'(cur_x_q) + $signed({2'b00, dmx_q}));
  assign ny = head_y_q[15] ? (36'(cur_y_q) - $signed({2'b00, dmy_q}))
                           : (36'(cur_y_q) + $signed({2'b00, dmy_q}));

  // Saturate a position sum to the signed 32 bit range
  always_comb begin
    if (nx > 36'sh0_7FFF_FFFF)       nx_sat = 32'sh7FFF_FFFF;
    else if (nx < -36'sh0_8000_0000) nx_sat = 32'sh8000_0000;
    else                             nx_sat = nx[31:0];
    if (ny > 36'sh0_7FFF_FFFF)       ny_sat = 32'sh7FFF_FFFF;
    else if (ny < -36'sh0_8000_0000) ny_sat = 32'sh8000_0000;
    else                             ny_sat = ny[31:0];
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and multiplier control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    mul_en  = 1'b0;
    mul_acc = 1'b0;
    mul_hi  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      aps_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.req_type == aps_pkg::REQ_TICK) ? aps_pkg::ST_SD
                                                          : aps_pkg::ST_FINISH;
        end
      end
      aps_pkg::ST_SD: begin
        mul_en = 1'b1; mul_a = MW'(speed_q); mul_b = MW'(dt_q);
        state_d = aps_pkg::ST_DXLO;
      end
      aps_pkg::ST_DXLO: begin
        mul_en = 1'b1; mul_a = prod_q[MW-1:0]; mul_b = MW'(magx);
        state_d = aps_pkg::ST_DXHI;
      end
      aps_pkg::ST_DXHI: begin
        mul_en = 1'b1; mul_acc = 1'b1; mul_hi = 1'b1;
        mul_a = MW'(sd_q[39:MW]); mul_b = MW'(magx);
        state_d = aps_pkg::ST_DYLO;
      end
      aps_pkg::ST_DYLO: begin
        mul_en = 1'b1; mul_a = sd_q[MW-1:0]; mul_b = MW'(magy);
        state_d = aps_pkg::ST_DYHI;
      end
      aps_pkg::ST_DYHI: begin
        mul_en = 1'b1; mul_acc = 1'b1; mul_hi = 1'b1;
        mul_a = MW'(sd_q[39:MW]); mul_b = MW'(magy);
        state_d = aps_pkg::ST_SQX;
      end
      aps_pkg::ST_SQX: begin
        mul_en = 1'b1; mul_a = MW'(ax); mul_b = MW'(ax);
        state_d = aps_pkg::ST_SQY;
      end
      aps_pkg::ST_SQY: begin
        mul_en = 1'b1; mul_a = MW'(ay); mul_b = MW'(ay);
        state_d = aps_pkg::ST_SQLD;
      end
      aps_pkg::ST_SQLD: begin
        state_d = sq_sum[64] ? aps_pkg::ST_PATH : aps_pkg::ST_SQRT;
      end
      aps_pkg::ST_SQRT: begin
        if (sq_bit_q[0]) state_d = aps_pkg::ST_PATH;
      end
      aps_pkg::ST_PATH: state_d = aps_pkg::ST_ATT;
      aps_pkg::ST_ATT: begin
        mul_en = 1'b1; mul_a = MW'(atten_q); mul_b = MW'(path_q);
        state_d = aps_pkg::ST_DIVLD;
      end
      aps_pkg::ST_DIVLD: state_d = aps_pkg::ST_DIVP;
      aps_pkg::ST_DIVP: begin
        if (div_cnt_q == 4'd1) state_d = aps_pkg::ST_XSET;
      end
      aps_pkg::ST_XSET: begin
        state_d = (div_quo_q[DW-1:29] != '0) ? aps_pkg::ST_AMP1 : aps_pkg::ST_TMUL;
      end
      aps_pkg::ST_TMUL: begin
        mul_en = 1'b1; mul_a = MW'(term_q); mul_b = MW'(xf_q);
        state_d = aps_pkg::ST_TDLD;
      end
      aps_pkg::ST_TDLD: state_d = aps_pkg::ST_TDIV;
      aps_pkg::ST_TDIV: begin
        if (div_cnt_q == 4'd1) state_d = aps_pkg::ST_TACC;
      end
      aps_pkg::ST_TACC: begin
        state_d = (k_q == aps_pkg::SERIES_TERMS) ? aps_pkg::ST_EMUL : aps_pkg::ST_TMUL;
      end
      aps_pkg::ST_EMUL: begin
        if (n_q == 5'd0) begin
          state_d = aps_pkg::ST_AMP1;
        end else begin
          mul_en = 1'b1; mul_a = MW'(sum_q); mul_b = MW'(aps_pkg::EXP_M1_Q32);
          state_d = aps_pkg::ST_EWB;
        end
      end
      aps_pkg::ST_EWB: state_d = aps_pkg::ST_EMUL;
      aps_pkg::ST_AMP1: begin
        mul_en = 1'b1; mul_a = MW'(base_q); mul_b = MW'(sum_q);
        state_d = aps_pkg::ST_AMP2;
      end
      aps_pkg::ST_AMP2: begin
        mul_en = 1'b1; mul_a = prod_q[16+MW-1:16]; mul_b = MW'(energy_q);
        state_d = aps_pkg::ST_AMP3;
      end
      aps_pkg::ST_AMP3: begin
        mul_en = 1'b1; mul_acc = 1'b1; mul_hi = 1'b1;
        mul_a = MW'(t_q[40:MW]); mul_b = MW'(energy_q);
        state_d = aps_pkg::ST_AMP4;
      end
      aps_pkg::ST_AMP4: state_d = aps_pkg::ST_FINISH;
      aps_pkg::ST_FINISH: begin
        if (out_free) state_d = aps_pkg::ST_IDLE;
      end
      default: state_d = aps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= aps_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // --------------------------------------------------------------------------
  // Particle state: launch loads, tick closes in ST_PATH and ST_AMP4
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      prv_x_q  <= '0;
      prv_y_q  <= '0;
      head_x_q <= '0;
      head_y_q <= '0;
      age_q    <= '0;
      path_q   <= '0;
      amp_q    <= aps_pkg::BASE_RST;
      dead_q   <= 1'b0;
    end else if (in_fire && in_i.req_type == aps_pkg::REQ_LAUNCH) begin
      cur_x_q  <= in_i.start_x;
      cur_y_q  <= in_i.start_y;
      prv_x_q  <= in_i.start_x;
      prv_y_q  <= in_i.start_y;
      head_x_q <= in_i.dir_x;
      head_y_q <= in_i.dir_y;
      age_q    <= '0;
      path_q   <= '0;
      amp_q    <= base_q;
      dead_q   <= 1'b0;
    end else if (state_q == aps_pkg::ST_PATH) begin
      path_q <= path_sum[32] ? 32'hFFFF_FFFF : path_sum[31:0];
      age_q  <= age_sum[32]  ? 32'hFFFF_FFFF : age_sum[31:0];
    end else if (state_q == aps_pkg::ST_AMP4) begin
      amp_q   <= amp_new;
      prv_x_q <= cur_x_q;
      prv_y_q <= cur_y_q;
      cur_x_q <= nx_sat;
      cur_y_q <= ny_sat;
      if (amp_new <= death_q) dead_q <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Working registers of a tick
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) dt_q <= in_i.dt;
    if (state_q == aps_pkg::ST_DXLO) sd_q  <= prod_q[39:0];
    if (state_q == aps_pkg::ST_DYLO) dmx_q <= prod_q[55:22];
    if (state_q == aps_pkg::ST_SQX)  dmy_q <= prod_q[55:22];
    if (state_q == aps_pkg::ST_SQY)  sqx_q <= prod_q[63:0];
    if (state_q == aps_pkg::ST_AMP2) t_q   <= prod_q[56:16];

    // square root: start on the sum of squares, then one digit a cycle
    if (state_q == aps_pkg::ST_SQLD) begin
      sq_ovf_q <= sq_sum[64];
      sq_v_q   <= sq_sum[63:0];
      sq_r_q   <= '0;
      sq_bit_q <= 64'h4000_0000_0000_0000;
    end else if (state_q == aps_pkg::ST_SQRT) begin
      sq_v_q   <= sq_ge ? (sq_v_q - sq_rb) : sq_v_q;
      sq_r_q   <= sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);
      sq_bit_q <= sq_bit_q >> 2;
    end

    // divider: load, then iterate
    if (state_q == aps_pkg::ST_DIVLD || state_q == aps_pkg::ST_TDLD) begin
      div_quo_q <= (state_q == aps_pkg::ST_DIVLD) ? prod_q[DW-1:0] : prod_q[DW+23:24];
      div_rem_q <= '0;
      div_cnt_q <= aps_pkg::DIV_CYC;
    end else if (state_q == aps_pkg::ST_DIVP || state_q == aps_pkg::ST_TDIV) begin
      div_quo_q <= div_quo_n;
      div_rem_q <= div_rem_n;
      div_cnt_q <= div_cnt_q - 4'd1;
    end

    // exponential: series on the fraction, then whole powers of 1/e
    case (state_q)
      aps_pkg::ST_XSET: begin
        n_q    <= div_quo_q[28:24];
        xf_q   <= div_quo_q[23:0];
        term_q <= aps_pkg::ONE_Q32;
        k_q    <= 4'd1;
        sum_q  <= (div_quo_q[DW-1:29] != '0) ? 33'd0 : aps_pkg::ONE_Q32;
      end
      aps_pkg::ST_TACC: begin
        term_q <= div_quo_q[32:0];
        sum_q  <= k_q[0] ? (sum_q - div_quo_q[32:0]) : (sum_q + div_quo_q[32:0]);
        k_q    <= k_q + 4'd1;
      end
      aps_pkg::ST_EWB: begin
        sum_q <= e_round[64:32];
        n_q   <= n_q - 5'd1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: load on finish, drop once taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == aps_pkg::ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == aps_pkg::ST_FINISH && out_free) begin
      out_o.cur_x     <= cur_x_q;
      out_o.cur_y     <= cur_y_q;
      out_o.prev_x    <= prv_x_q;
      out_o.prev_y    <= prv_y_q;
      out_o.amplitude <= amp_q;
      out_o.travelled <= path_q;
      out_o.age       <= age_q;
      out_o.is_dead   <= dead_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "attenuating_particle_step_top_assert.svh"

  `APS_ASSERT_NOW(a_busy_no_accept, state_q != aps_pkg::ST_IDLE, !in_i.ready, "request taken while busy")
  `APS_ASSERT_NEXT(a_dead_sticky, dead_q && !(in_fire && in_i.req_type == aps_pkg::REQ_LAUNCH), dead_q, "dead flag cleared without launch")
  `APS_ASSERT_NOW(a_div_count, state_q == aps_pkg::ST_DIVP || state_q == aps_pkg::ST_TDIV, div_cnt_q != 4'd0, "divider ran past its last step")

endmodule
